@@ rtl/assert_macros.svh @@
// concurrent assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define IPDV_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define IPDV_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define IPDV_ASSERT(lbl, clk, rst_n, prop)
`define IPDV_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ rtl/ipdv_pkg.sv @@
`timescale 1ns / 1ps

package ipdv_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int COORD_IN_W      = 32;
	localparam int DELTA_W         = 33;
	localparam int ZZ_W            = 34;
	localparam int PRESS_IN_W      = 18;
	localparam int PRESS_W         = 16;
	localparam int TILT_IN_W       = 16;
	localparam int TIME_W          = 32;
	localparam int FIX_BYTES       = 4;

	localparam logic [16:0] PRESS_ONE   = 17'h10000;
	localparam logic [32:0] PRESS_SCALE = 33'h0_0000_FFFF;
	localparam logic [32:0] PRESS_HALF  = 33'h0_0000_8000;

	localparam logic signed [TILT_IN_W-1:0] TILT_MAX = 16'sd127;
	localparam logic signed [TILT_IN_W-1:0] TILT_MIN = -16'sd127;

	typedef struct packed {
		logic [ZZ_W-1:0]          zz_x;
		logic [ZZ_W-1:0]          zz_y;
		logic [FIX_BYTES*8-1:0]   fixed_bytes;
		logic [TIME_W-1:0]        time_delta;
	} ipdv_rec_t;

endpackage

@@ rtl/ipdv_in_if.sv @@
`timescale 1ns / 1ps

interface ipdv_in_if import ipdv_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic                         start_of_stroke;
	logic signed [COORD_IN_W-1:0] x_fixed;
	logic signed [COORD_IN_W-1:0] y_fixed;
	logic signed [PRESS_IN_W-1:0] pressure_q16;
	logic signed [TILT_IN_W-1:0]  tilt_x;
	logic signed [TILT_IN_W-1:0]  tilt_y;
	logic [TIME_W-1:0]            time_ms;

	modport source (
		output valid, start_of_stroke, x_fixed, y_fixed, pressure_q16, tilt_x, tilt_y,
			time_ms,
		input ready
	);
	modport sink (
		input valid, start_of_stroke, x_fixed, y_fixed, pressure_q16, tilt_x, tilt_y,
			time_ms,
		output ready
	);
endinterface

@@ rtl/ipdv_out_if.sv @@
`timescale 1ns / 1ps

interface ipdv_out_if import ipdv_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;

	modport source (output valid, out_byte, last_byte, input ready);
	modport sink (input valid, out_byte, last_byte, output ready);
endinterface

@@ rtl/ipdv_point.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipdv_point import ipdv_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ipdv_in_if.sink   in_ch,
	output ipdv_rec_t rec,
	output logic      rec_valid,
	input  logic      rec_ready
);

	localparam int CWE = (COORD_WIDTH < COORD_IN_W) ? COORD_WIDTH : COORD_IN_W;

	logic [COORD_IN_W-1:0] prev_x_q, prev_y_q;
	logic [TIME_W-1:0]     prev_time_q;
	ipdv_rec_t             rec_s1;
	logic                  valid_s1;

	logic signed [DELTA_W-1:0] x_e, y_e, px_e, py_e, dx, dy;
	logic [TIME_W-1:0]         pt;
	logic [16:0]               p_clamp;
	logic [32:0]               p_prod;
	logic [PRESS_W-1:0]        q;
	logic [7:0]                tx_b, ty_b;
	ipdv_rec_t                 rec_d;
	logic                      accept;

	function automatic logic [7:0] clamp_tilt(logic signed [TILT_IN_W-1:0] t);
		logic [7:0] r;
		if (t > TILT_MAX) begin
			r = TILT_MAX[7:0];
		end else if (t < TILT_MIN) begin
			r = TILT_MIN[7:0];
		end else begin
			r = t[7:0];
		end
		return r;
	endfunction

	assign accept       = in_ch.valid && in_ch.ready;
	assign in_ch.ready  = !valid_s1 || rec_ready;
	assign rec          = rec_s1;
	assign rec_valid    = valid_s1;

	always_comb begin
		x_e  = DELTA_W'($signed(in_ch.x_fixed[CWE-1:0]));
		y_e  = DELTA_W'($signed(in_ch.y_fixed[CWE-1:0]));
		px_e = in_ch.start_of_stroke ? '0 : DELTA_W'($signed(prev_x_q));
		py_e = in_ch.start_of_stroke ? '0 : DELTA_W'($signed(prev_y_q));
		pt   = in_ch.start_of_stroke ? '0 : prev_time_q;
		dx   = x_e - px_e;
		dy   = y_e - py_e;

		if (in_ch.pressure_q16[PRESS_IN_W-1]) begin
			p_clamp = '0;
		end else if (in_ch.pressure_q16[PRESS_IN_W-2:0] > PRESS_ONE) begin
			p_clamp = PRESS_ONE;
		end else begin
			p_clamp = in_ch.pressure_q16[PRESS_IN_W-2:0];
		end
		p_prod = 33'(p_clamp) * PRESS_SCALE + PRESS_HALF;
		q      = p_prod[31:16];

		tx_b = clamp_tilt(in_ch.tilt_x);
		ty_b = clamp_tilt(in_ch.tilt_y);

		rec_d.zz_x        = {dx, 1'b0} ^ {ZZ_W{dx[DELTA_W-1]}};
		rec_d.zz_y        = {dy, 1'b0} ^ {ZZ_W{dy[DELTA_W-1]}};
		rec_d.fixed_bytes = {ty_b, tx_b, q[15:8], q[7:0]};
		rec_d.time_delta  = (in_ch.time_ms >= pt) ? in_ch.time_ms - pt : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_time_q <= '0;
			valid_s1    <= 1'b0;
		end else if (accept) begin
			prev_x_q    <= x_e[COORD_IN_W-1:0];
			prev_y_q    <= y_e[COORD_IN_W-1:0];
			prev_time_q <= in_ch.time_ms;
			valid_s1    <= 1'b1;
		end else if (rec_ready) begin
			valid_s1    <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_s1 <= rec_d;
		end
	end

	`IPDV_ASSERT(a_rec_held, clk, arst_n,
		(valid_s1 && !rec_ready) |=> (valid_s1 && $stable(rec_s1)))
	`IPDV_ASSERT(a_time_tracked, clk, arst_n,
		accept |=> (prev_time_q == $past(in_ch.time_ms)))

endmodule

@@ rtl/ipdv_ser.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipdv_ser import ipdv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ipdv_rec_t  rec,
	input  logic       rec_valid,
	output logic       rec_ready,
	ipdv_out_if.source out_ch
);

	typedef enum logic [1:0] {
		SEG_X,
		SEG_Y,
		SEG_FIX,
		SEG_T
	} seg_t;

	seg_t                   seg_q;
	logic                   valid_q;
	logic [ZZ_W-1:0]        val_q;
	logic [ZZ_W-1:0]        zz_y_q;
	logic [FIX_BYTES*8-1:0] fix_q;
	logic [TIME_W-1:0]      td_q;
	logic [1:0]             fix_cnt_q;

	logic more;
	logic xfer;
	logic last;

	assign more = |val_q[ZZ_W-1:7];
	assign last = (seg_q == SEG_T) && !more;
	assign xfer = out_ch.valid && out_ch.ready;

	assign out_ch.valid     = valid_q;
	assign out_ch.last_byte = last;
	assign out_ch.out_byte  = (seg_q == SEG_FIX) ? fix_q[7:0] : {more, val_q[6:0]};

	assign rec_ready = !valid_q || (xfer && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q     <= SEG_X;
			valid_q   <= 1'b0;
			fix_cnt_q <= '0;
		end else if (rec_ready) begin
			valid_q   <= rec_valid;
			seg_q     <= SEG_X;
			fix_cnt_q <= '0;
		end else if (xfer) begin
			unique case (seg_q)
				SEG_X: begin
					if (!more) begin
						seg_q <= SEG_Y;
					end
				end
				SEG_Y: begin
					if (!more) begin
						seg_q <= SEG_FIX;
					end
				end
				SEG_FIX: begin
					fix_cnt_q <= fix_cnt_q + 2'd1;
					if (fix_cnt_q == 2'(FIX_BYTES - 1)) begin
						seg_q <= SEG_T;
					end
				end
				SEG_T: begin
					seg_q <= SEG_T;
				end
				default: begin
					seg_q <= SEG_X;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rec_ready) begin
			val_q  <= rec.zz_x;
			zz_y_q <= rec.zz_y;
			fix_q  <= rec.fixed_bytes;
			td_q   <= rec.time_delta;
		end else if (xfer) begin
			if (seg_q == SEG_FIX) begin
				fix_q <= fix_q >> 8;
				if (fix_cnt_q == 2'(FIX_BYTES - 1)) begin
					val_q <= ZZ_W'(td_q);
				end
			end else if (more) begin
				val_q <= val_q >> 7;
			end else if (seg_q == SEG_X) begin
				val_q <= zz_y_q;
			end
		end
	end

	`IPDV_ASSERT(a_cnt_only_fix, clk, arst_n, (seg_q != SEG_FIX) |-> (fix_cnt_q == 2'd0))
	`IPDV_ASSERT(a_no_early_end, clk, arst_n, (xfer && !last) |=> valid_q)
	`IPDV_ASSERT_NEVER(a_no_overrun, clk, arst_n, valid_q && !xfer && rec_ready)

endmodule

@@ rtl/ink_point_delta_varint_encoder.sv @@
`timescale 1ns / 1ps
// channel  dir  payload                                          transfer
// in_ch    in   start_of_stroke x_fixed y_fixed pressure_q16     valid && ready
//               tilt_x tilt_y time_ms
// out_ch   out  out_byte last_byte                               valid && ready
//
// a point is encoded in the cycle it is taken and queued in a record register
// the byte serializer sends one byte per cycle while out_ch is ready and a point is queued, 7 to 19 bytes per point
// sustained rate is set by that serializer: one point per record length
// a new point is taken while the serializer still works on the previous one
// out_ch stalls hold the serializer; reset clears the predictors and valids

module ink_point_delta_varint_encoder import ipdv_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ipdv_in_if.sink    in_ch,
	ipdv_out_if.source out_ch
);

	ipdv_rec_t rec;
	logic      rec_valid;
	logic      rec_ready;

	ipdv_point #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_point (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.rec      (rec),
		.rec_valid(rec_valid),
		.rec_ready(rec_ready)
	);

	ipdv_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec      (rec),
		.rec_valid(rec_valid),
		.rec_ready(rec_ready),
		.out_ch   (out_ch)
	);

endmodule

@@ test/tb_ink_point_delta_varint_encoder.sv @@
`timescale 1ns / 1ps

module tb_ink_point_delta_varint_encoder;
	import ipdv_pkg::*;

	localparam int CW_EFF = (COORD_WIDTH_DEF < 32) ? COORD_WIDTH_DEF : 32;
	localparam int RANDOM_POINTS = 310;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic                  sos;
		logic [COORD_IN_W-1:0] x;
		logic [COORD_IN_W-1:0] y;
		logic [PRESS_IN_W-1:0] p;
		logic [TILT_IN_W-1:0]  tx;
		logic [TILT_IN_W-1:0]  ty;
		logic [TIME_W-1:0]     t;
	} point_t;

	typedef struct {
		logic [7:0] data;
		logic       is_last;
	} rec_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	ipdv_in_if in_ch ();
	ipdv_out_if out_ch ();

	ink_point_delta_varint_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	point_t    pending_points[$];
	rec_byte_t expected_bytes[$];
	rec_byte_t point_record[$];

	longint            pred_x = 0;
	longint            pred_y = 0;
	logic [TIME_W-1:0] pred_t = '0;

	int mismatches = 0;
	int idle_cycles = 0;

	int     send_gap = 0;
	bit     in_burst = 1'b0;
	int     stall_left = 0;
	bit     out_burst = 1'b0;
	point_t next_pt;
	point_t taken_pt;
	rec_byte_t want;

	function automatic longint coord_value(logic [COORD_IN_W-1:0] raw);
		logic [63:0] u;
		u = {{(64 - COORD_IN_W){1'b0}}, raw} << (64 - CW_EFF);
		return $signed(u) >>> (64 - CW_EFF);
	endfunction

	function automatic logic [63:0] zigzag64(longint d);
		if (d < 0)
			return 64'(-d * 2 - 1);
		return 64'(d * 2);
	endfunction

	function automatic longint clamp_range(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void append_byte(logic [7:0] d);
		point_record.push_back('{data: d, is_last: 1'b0});
	endfunction

	function automatic void append_varint(logic [63:0] v);
		while (v >= 64'h80) begin
			append_byte({1'b1, v[6:0]});
			v = v >> 7;
		end
		append_byte(v[7:0]);
	endfunction

	function automatic void encode_point(point_t pt);
		longint            cx;
		longint            cy;
		longint            pr;
		logic [63:0]       q;
		logic [TIME_W-1:0] dt;
		point_record.delete();
		if (pt.sos) begin
			pred_x = 0;
			pred_y = 0;
			pred_t = '0;
		end
		cx = coord_value(pt.x);
		cy = coord_value(pt.y);
		append_varint(zigzag64(cx - pred_x));
		append_varint(zigzag64(cy - pred_y));
		pred_x = cx;
		pred_y = cy;
		pr = $signed(pt.p);
		pr = clamp_range(pr, 0, longint'(PRESS_ONE));
		q = (64'(pr) * 64'd65535 + 64'd32768) >> 16;
		append_byte(q[7:0]);
		append_byte(q[15:8]);
		append_byte(8'(clamp_range($signed(pt.tx), -127, 127)));
		append_byte(8'(clamp_range($signed(pt.ty), -127, 127)));
		dt = (pt.t >= pred_t) ? pt.t - pred_t : '0;
		pred_t = pt.t;
		append_varint({32'b0, dt});
		point_record[point_record.size() - 1].is_last = 1'b1;
		foreach (point_record[i])
			expected_bytes.push_back(point_record[i]);
	endfunction

	function automatic point_t make_pt(bit sos, logic [31:0] x, logic [31:0] y,
			logic [PRESS_IN_W-1:0] p, logic [15:0] tx, logic [15:0] ty, logic [31:0] t);
		point_t pt;
		pt.sos = sos;
		pt.x = x;
		pt.y = y;
		pt.p = p;
		pt.tx = tx;
		pt.ty = ty;
		pt.t = t;
		return pt;
	endfunction

	function automatic logic [31:0] rand_step();
		int          w;
		logic [31:0] v;
		w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32) : $urandom_range(0, 9);
		v = $urandom & ((32'd1 << w) - 32'd1);
		if (w == 32)
			v = $urandom;
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	initial begin : stimulus
		logic [31:0] gen_x;
		logic [31:0] gen_y;
		logic [31:0] gen_t;
		point_t      pt;
		int          kind;

		in_ch.valid = 1'b0;
		in_ch.start_of_stroke = 1'b0;
		in_ch.x_fixed = '0;
		in_ch.y_fixed = '0;
		in_ch.pressure_q16 = '0;
		in_ch.tilt_x = '0;
		in_ch.tilt_y = '0;
		in_ch.time_ms = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;

		// extremes, varint length boundaries, clamps, backwards time, mid-stroke restart
		pending_points.push_back(make_pt(1, 0, 0, 0, 0, 0, 0));
		pending_points.push_back(make_pt(0, 32'h7fffffff, 32'h80000000, 18'h20000,
			16'h8000, 16'h7fff, 32'hffffffff));
		pending_points.push_back(make_pt(0, 32'h80000000, 32'h7fffffff, 18'h1ffff,
			16'h7fff, 16'h8000, 0));
		pending_points.push_back(make_pt(1, 63, -64, 18'h10000, 127, -127, 127));
		pending_points.push_back(make_pt(0, 127, -129, 65535, 128, -128, 255));
		pending_points.push_back(make_pt(0, 127, -129, 32768, -127, 127, 255));
		pending_points.push_back(make_pt(0, 126, -128, 1, 0, 0, 254));
		pending_points.push_back(make_pt(1, -1, 1, 0, 1, -1, 16384));
		pending_points.push_back(make_pt(0, 32'h80000000, 32'h80000000, 2, 200, -200,
			32'h80000000));
		pending_points.push_back(make_pt(1, 32'h80000000, 32'h7fffffff, 18'h3ffff, 0, 0,
			32'hffffffff));
		pending_points.push_back(make_pt(0, 0, 0, 65537, -1, 1, 32'hffffffff));
		pending_points.push_back(make_pt(1, 0, 0, 32767, 0, 0, 1));
		pending_points.push_back(make_pt(0, 8191, -8192, 65534, -126, 126, 16385));

		gen_x = 0;
		gen_y = 0;
		gen_t = 16385;
		repeat (RANDOM_POINTS) begin
			kind = $urandom_range(0, 9);
			pt.sos = ($urandom_range(0, 11) == 0);
			if (kind == 0) begin
				pt.x = $urandom;
				pt.y = $urandom;
				pt.p = 18'($urandom);
				pt.tx = 16'($urandom);
				pt.ty = 16'($urandom);
				pt.t = $urandom;
			end else begin
				pt.x = gen_x + rand_step();
				pt.y = gen_y + rand_step();
				pt.p = ($urandom_range(0, 4) == 0) ? 18'($urandom) :
					18'($urandom_range(0, 65536));
				pt.tx = ($urandom_range(0, 5) == 0) ? 16'($urandom) :
					16'($urandom_range(0, 300) - 150);
				pt.ty = ($urandom_range(0, 5) == 0) ? 16'($urandom) :
					16'($urandom_range(0, 300) - 150);
				if ($urandom_range(0, 15) == 0)
					pt.t = gen_t - $urandom_range(1, 1000);
				else if ($urandom_range(0, 3) == 0)
					pt.t = gen_t + $urandom_range(0, 100000);
				else
					pt.t = gen_t + $urandom_range(0, 40);
			end
			gen_x = pt.x;
			gen_y = pt.y;
			gen_t = pt.t;
			pending_points.push_back(pt);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending_points.size() != 0 || in_ch.valid || expected_bytes.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (expected_bytes.size() != 0) begin
			mismatches++;
			$display("%0d record bytes never sent", expected_bytes.size());
		end
		if (mismatches == 0)
			$display("tb_ink_point_delta_varint_encoder: done, clean");
		else
			$display("tb_ink_point_delta_varint_encoder: done, errors");
		$finish;
	end

	// point driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				send_gap = in_burst ? 0 : pick_gap();
				if ($urandom_range(0, 31) == 0)
					in_burst = !in_burst;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0 || pending_points.size() == 0) begin
					if (send_gap > 0)
						send_gap--;
					in_ch.valid <= 1'b0;
				end else begin
					next_pt = pending_points.pop_front();
					in_ch.start_of_stroke <= next_pt.sos;
					in_ch.x_fixed <= next_pt.x;
					in_ch.y_fixed <= next_pt.y;
					in_ch.pressure_q16 <= next_pt.p;
					in_ch.tilt_x <= next_pt.tx;
					in_ch.tilt_y <= next_pt.ty;
					in_ch.time_ms <= next_pt.t;
					in_ch.valid <= 1'b1;
				end
			end
		end
	end

	// byte sink back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left == 0 && !out_burst && $urandom_range(0, 5) == 0)
				stall_left = pick_gap();
			out_ch.ready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
			if ($urandom_range(0, 199) == 0)
				out_burst = !out_burst;
		end
	end

	// monitor: predict on point transfer, check on byte transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				taken_pt.sos = in_ch.start_of_stroke;
				taken_pt.x = in_ch.x_fixed;
				taken_pt.y = in_ch.y_fixed;
				taken_pt.p = in_ch.pressure_q16;
				taken_pt.tx = in_ch.tilt_x;
				taken_pt.ty = in_ch.tilt_y;
				taken_pt.t = in_ch.time_ms;
				encode_point(taken_pt);
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_bytes.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected byte %02h last %0b", out_ch.out_byte,
							out_ch.last_byte);
				end else begin
					want = expected_bytes.pop_front();
					if (out_ch.out_byte !== want.data || out_ch.last_byte !== want.is_last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("byte mismatch: expected %02h last %0b, got %02h last %0b",
								want.data, want.is_last, out_ch.out_byte, out_ch.last_byte);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_ink_point_delta_varint_encoder: done, errors");
				$finish;
			end
		end
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ipdv_pkg.sv
rtl/ipdv_in_if.sv
rtl/ipdv_out_if.sv
rtl/ipdv_point.sv
rtl/ipdv_ser.sv
rtl/ink_point_delta_varint_encoder.sv
test/tb_ink_point_delta_varint_encoder.sv
